>>> hdl/horizon_line_endpoints_top_assert.svh
// Assertion macros used by the top-level RTL file
`ifndef HORIZON_LINE_ENDPOINTS_TOP_ASSERT_SVH
`define HORIZON_LINE_ENDPOINTS_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// full form: explicit clock and active-low reset
`define HLE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// usual form on clk_i / rst_ni
`define HLE_ASSERT(lbl, prop, msg) `HLE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define HLE_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define HLE_ASSERT(lbl, prop, msg)
`endif

`endif

>>> hdl/hle_pkg.sv
package hle_pkg;

  localparam int CHAR_WIDTH      = 12;
  localparam int CHAR_HEIGHT     = 18;
  localparam int BAR_CHARS       = 5;
  localparam int SYMBOL_ROWS     = 9;
  localparam int ROW_SHIFT       = (SYMBOL_ROWS - 1) / 2;
  localparam int BAR_LEN         = BAR_CHARS * CHAR_WIDTH;
  localparam int CORDIC_STEPS    = 16;
  localparam int DIV_STEPS       = 18;
  localparam int MAX_PITCH_LIMIT = 89;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // register indexes
  typedef enum logic [1:0] {
    CFG_INVERT       = 2'd0,
    CFG_MAX_PITCH    = 2'd1,
    CFG_SCREEN_LINES = 2'd2
  } cfg_idx_e;

  // one rotation lane, Q2.30 x/y, angle in 1/65536 tenth-degree
  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [27:0] z;
    logic               flip;
  } lane_t;

  // sideband carried along the whole chain
  typedef struct packed {
    logic [5:0]         col;
    logic [4:0]         row;
    logic               oor;
    logic               en;
    logic signed [10:0] disp;
    logic signed [15:0] sr;
    logic signed [15:0] cr;
  } side_t;

  // restoring divider word
  typedef struct packed {
    logic [46:0] part;
    logic [29:0] den;
    logic [17:0] quot;
    logic        neg;
  } div_t;

  function automatic logic signed [27:0] atan_step(input logic [3:0] i);
    logic signed [27:0] a;
    unique case (i)
      4'd0:  a = 28'sd29491200;
      4'd1:  a = 28'sd17409672;
      4'd2:  a = 28'sd9198793;
      4'd3:  a = 28'sd4669451;
      4'd4:  a = 28'sd2343787;
      4'd5:  a = 28'sd1173036;
      4'd6:  a = 28'sd586661;
      4'd7:  a = 28'sd293348;
      4'd8:  a = 28'sd146676;
      4'd9:  a = 28'sd73339;
      4'd10: a = 28'sd36669;
      4'd11: a = 28'sd18335;
      4'd12: a = 28'sd9167;
      4'd13: a = 28'sd4584;
      4'd14: a = 28'sd2292;
      default: a = 28'sd1146;
    endcase
    return a;
  endfunction

  // wrap to +-180 deg, fold into +-90 deg, seed the rotator
  function automatic lane_t init_lane(input logic signed [12:0] ang);
    lane_t l;
    logic signed [12:0] a;
    logic               f;
    a = ang;
    f = 1'b0;
    if (a > 13'sd1800) a = a - 13'sd3600;
    if (a < -13'sd1800) a = a + 13'sd3600;
    if (a > 13'sd900) begin
      a = a - 13'sd1800;
      f = 1'b1;
    end else if (a < -13'sd900) begin
      a = a + 13'sd1800;
      f = 1'b1;
    end
    l.x = CORDIC_GAIN;
    l.y = '0;
    l.z = 28'($signed({a, 16'h0000}));
    l.flip = f;
    return l;
  endfunction

  // Q2.30 to Q1.15, toward zero, magnitude limited
  function automatic logic signed [15:0] to_q15(input logic signed [32:0] v,
                                                input logic flip);
    logic signed [33:0] w;
    logic signed [33:0] q;
    w = flip ? -34'(v) : 34'(v);
    q = (w < 0) ? ((w + 34'sd32767) >>> 15) : (w >>> 15);
    if (q > 34'sd32767) q = 34'sd32767;
    if (q < -34'sd32767) q = -34'sd32767;
    return 16'(q);
  endfunction

  // divide by 2^15 toward zero, wrap to 16 bits
  function automatic logic [15:0] trunc15(input logic signed [33:0] s);
    logic signed [33:0] q;
    q = (s < 0) ? ((s + 34'sd32767) >>> 15) : (s >>> 15);
    return q[15:0];
  endfunction

endpackage

>>> hdl/hle_cordic_cell.sv
module hle_cordic_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           step_i,
  input  logic                 valid_i,
  input  hle_pkg::lane_t [2:0] lanes_i,
  input  hle_pkg::side_t       side_i,
  output logic                 valid_o,
  output hle_pkg::lane_t [2:0] lanes_o,
  output hle_pkg::side_t       side_o
);
  import hle_pkg::*;

  logic               valid_q;
  lane_t [2:0]        lanes_d, lanes_q;
  side_t              side_q;
  logic signed [27:0] atan_w;

  assign atan_w = atan_step(step_i);

  // one micro-rotation per lane
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lanes_d[k] = lanes_i[k];
      if (!lanes_i[k].z[27]) begin
        lanes_d[k].x = lanes_i[k].x - ($signed(lanes_i[k].y) >>> step_i);
        lanes_d[k].y = lanes_i[k].y + ($signed(lanes_i[k].x) >>> step_i);
        lanes_d[k].z = lanes_i[k].z - atan_w;
      end else begin
        lanes_d[k].x = lanes_i[k].x + ($signed(lanes_i[k].y) >>> step_i);
        lanes_d[k].y = lanes_i[k].y - ($signed(lanes_i[k].x) >>> step_i);
        lanes_d[k].z = lanes_i[k].z + atan_w;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
    side_q  <= side_i;
  end

  assign valid_o = valid_q;
  assign lanes_o = lanes_q;
  assign side_o  = side_q;

endmodule

>>> hdl/hle_div_cell.sv
module hle_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     step_i,
  input  logic           valid_i,
  input  hle_pkg::div_t  div_i,
  input  hle_pkg::side_t side_i,
  output logic           valid_o,
  output hle_pkg::div_t  div_o,
  output hle_pkg::side_t side_o
);
  import hle_pkg::*;

  logic        valid_q;
  div_t        div_d, div_q;
  side_t       side_q;
  logic [46:0] den_sh;

  assign den_sh = {17'd0, div_i.den} << step_i;

  // one quotient bit: compare and subtract
  always_comb begin
    div_d = div_i;
    if (div_i.part >= den_sh) begin
      div_d.part = div_i.part - den_sh;
      div_d.quot = div_i.quot | (18'd1 << step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    side_q <= side_i;
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign side_o  = side_q;

endmodule

>>> hdl/horizon_line_endpoints_top.sv
// Channel   Handshake           Words
// input     start / busy        col_i row_i roll_i pitch_i
// result    done_o strobe       start_x_o start_y_o end_x_o end_y_o out_of_range_o
// config    cfg_we_i            cfg_idx_i cfg_wdata_i
//
// A word is taken in every cycle; busy stays low.
// Each result passes through 16 CORDIC cells, 18 divider cells and six single
// stages after its word is taken.
// Reset sets the config registers to their defaults and clears every valid bit; no clearing pass.
// The receiver cannot stall; done_o is high for one cycle per result.
module horizon_line_endpoints_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         col_i,
  input  logic [4:0]         row_i,
  input  logic signed [11:0] roll_i,
  input  logic signed [11:0] pitch_i,
  output logic               done_o,
  output logic signed [15:0] start_x_o,
  output logic signed [15:0] start_y_o,
  output logic signed [15:0] end_x_o,
  output logic signed [15:0] end_y_o,
  output logic               out_of_range_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i
);
  import hle_pkg::*;

  localparam int LAT = 40;

  // config registers
  logic       invert_q;
  logic [6:0] max_pitch_q;
  logic [9:0] screen_lines_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q       <= 1'b0;
      max_pitch_q    <= 7'd20;
      screen_lines_q <= 10'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INVERT:       invert_q       <= cfg_wdata_i[0];
        CFG_MAX_PITCH:    max_pitch_q    <= cfg_wdata_i[6:0];
        CFG_SCREEN_LINES: screen_lines_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // input stage: sign, clamp, angle seeds
  logic signed [12:0] roll_s, pitch_s, clamp_s, maxp_s;
  logic [6:0]         limit;
  logic [9:0]         maxp;
  logic signed [10:0] dl, disp;
  lane_t [2:0]        seed;
  side_t              seed_side;

  always_comb begin
    roll_s  = invert_q ? -13'(roll_i) : 13'(roll_i);
    pitch_s = invert_q ? -13'(pitch_i) : 13'(pitch_i);
    limit   = (max_pitch_q > 7'(MAX_PITCH_LIMIT)) ? 7'(MAX_PITCH_LIMIT) : max_pitch_q;
    maxp    = 10'(limit) * 10'd10;
    maxp_s  = $signed({3'b000, maxp});
    clamp_s = pitch_s;
    if (clamp_s > maxp_s) clamp_s = maxp_s;
    if (clamp_s < -maxp_s) clamp_s = -maxp_s;
    dl   = $signed({1'b0, screen_lines_q}) - 11'sd64;
    disp = (dl < 0) ? -((-dl) >>> 1) : (dl >>> 1);
    seed[0] = init_lane(roll_s);
    seed[1] = init_lane(clamp_s);
    seed[2] = init_lane(maxp_s);
    seed_side.col  = col_i;
    seed_side.row  = row_i;
    seed_side.oor  = (clamp_s != pitch_s);
    seed_side.en   = (maxp != 10'd0);
    seed_side.disp = disp;
    seed_side.sr   = '0;
    seed_side.cr   = '0;
  end

  logic        c_valid [0:CORDIC_STEPS];
  lane_t [2:0] c_lanes [0:CORDIC_STEPS];
  side_t       c_side  [0:CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid[0] <= 1'b0;
    end else begin
      c_valid[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    c_lanes[0] <= seed;
    c_side[0]  <= seed_side;
  end

  // rotator chain
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    hle_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (4'(i)),
      .valid_i (c_valid[i]),
      .lanes_i (c_lanes[i]),
      .side_i  (c_side[i]),
      .valid_o (c_valid[i+1]),
      .lanes_o (c_lanes[i+1]),
      .side_o  (c_side[i+1])
    );
  end

  // Q1.15 conversion
  logic               q_valid_q;
  side_t              q_side_d, q_side_q;
  logic signed [15:0] sp_q, cp_q, sm_q, cm_q;

  always_comb begin
    q_side_d    = c_side[CORDIC_STEPS];
    q_side_d.cr = to_q15(c_lanes[CORDIC_STEPS][0].x, c_lanes[CORDIC_STEPS][0].flip);
    q_side_d.sr = to_q15(c_lanes[CORDIC_STEPS][0].y, c_lanes[CORDIC_STEPS][0].flip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else begin
      q_valid_q <= c_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    q_side_q    <= q_side_d;
    cp_q        <= to_q15(c_lanes[CORDIC_STEPS][1].x, c_lanes[CORDIC_STEPS][1].flip);
    sp_q        <= to_q15(c_lanes[CORDIC_STEPS][1].y, c_lanes[CORDIC_STEPS][1].flip);
    cm_q        <= to_q15(c_lanes[CORDIC_STEPS][2].x, c_lanes[CORDIC_STEPS][2].flip);
    sm_q        <= to_q15(c_lanes[CORDIC_STEPS][2].y, c_lanes[CORDIC_STEPS][2].flip);
  end

  // numerator and denominator products
  logic               m_valid_q;
  side_t              m_side_q;
  logic signed [31:0] num_q, den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= q_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_side_q <= q_side_q;
    num_q    <= 32'(sp_q) * 32'(cm_q);
    den_q    <= 32'(cp_q) * 32'(sm_q);
  end

  // divider entry, magnitude form
  logic        d_valid [0:DIV_STEPS];
  div_t        d_div   [0:DIV_STEPS];
  side_t       d_side  [0:DIV_STEPS];
  logic [30:0] num_mag;

  always_comb begin
    num_mag = (num_q < 0) ? 31'(-num_q) : 31'(num_q);
    d_valid[0] = m_valid_q;
    d_side[0]  = m_side_q;
    d_div[0].quot = '0;
    if (m_side_q.en) begin
      d_div[0].part = {num_mag, 16'h0000};
      d_div[0].den  = den_q[29:0];
      d_div[0].neg  = (num_q < 0);
    end else begin
      d_div[0].part = '0;
      d_div[0].den  = 30'd1;
      d_div[0].neg  = 1'b0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    hle_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .step_i  (5'(DIV_STEPS - 1 - k)),
      .valid_i (d_valid[k]),
      .div_i   (d_div[k]),
      .side_i  (d_side[k]),
      .valid_o (d_valid[k+1]),
      .div_o   (d_div[k+1]),
      .side_o  (d_side[k+1])
    );
  end

  // ratio times displacement
  logic               s_valid_q;
  side_t              s_side_q;
  logic signed [29:0] tscale_q;
  logic signed [18:0] ratio;

  assign ratio = d_div[DIV_STEPS].neg ? -$signed({1'b0, d_div[DIV_STEPS].quot})
                                      : $signed({1'b0, d_div[DIV_STEPS].quot});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= d_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    s_side_q <= d_side[DIV_STEPS];
    tscale_q <= 30'(ratio) * 30'(d_side[DIV_STEPS].disp);
  end

  // offsets along the roll normal
  logic               o_valid_q;
  side_t              o_side_q;
  logic signed [45:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= s_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_side_q <= s_side_q;
    px_q     <= 46'(tscale_q) * 46'(s_side_q.sr);
    py_q     <= 46'(tscale_q) * 46'(s_side_q.cr);
  end

  // centre and endpoints
  logic signed [45:0] xo_full, yo_full;
  logic signed [17:0] xoff, yoff, xc, yc;
  logic signed [33:0] bx, by, xs, ys;

  always_comb begin
    xo_full = (px_q < 0) ? ((px_q + 46'sd2147483647) >>> 31) : (px_q >>> 31);
    yo_full = (py_q < 0) ? ((py_q + 46'sd2147483647) >>> 31) : (py_q >>> 31);
    xoff = 18'(xo_full);
    yoff = 18'(yo_full);
    xc = $signed({12'd0, o_side_q.col}) * 18'(CHAR_WIDTH) + 18'(CHAR_WIDTH / 2) - xoff;
    yc = ($signed({13'd0, o_side_q.row}) + 18'(ROW_SHIFT)) * 18'(CHAR_HEIGHT)
         + 18'(CHAR_HEIGHT / 2) - yoff;
    bx = 34'(o_side_q.cr) * 34'(BAR_LEN);
    by = 34'(o_side_q.sr) * 34'(BAR_LEN);
    xs = 34'(xc) <<< 15;
    ys = 34'(yc) <<< 15;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= o_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    start_x_o      <= $signed(trunc15(xs + bx));
    start_y_o      <= $signed(trunc15(ys - by));
    end_x_o        <= $signed(trunc15(xs - bx));
    end_y_o        <= $signed(trunc15(ys + by));
    out_of_range_o <= o_side_q.oor;
  end

`include "horizon_line_endpoints_top_assert.svh"

  `HLE_ASSERT(a_lat_fwd, (start && !busy) |-> ##LAT done_o, "accepted word lost")
  `HLE_ASSERT(a_lat_bwd, done_o |-> $past(start && !busy, LAT), "result without word")
  `HLE_ASSERT(a_no_disp, (o_valid_q && !o_side_q.en) |-> (px_q == '0 && py_q == '0), "offset with zero limit")

endmodule

>>> verif/horizon_line_endpoints_checker.sv
`default_nettype none

module horizon_line_endpoints_checker
  import hle_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [5:0]         col_i,
  input  logic [4:0]         row_i,
  input  logic signed [11:0] roll_i,
  input  logic signed [11:0] pitch_i,
  input  logic               done_o,
  input  logic signed [15:0] start_x_o,
  input  logic signed [15:0] start_y_o,
  input  logic signed [15:0] end_x_o,
  input  logic signed [15:0] end_y_o,
  input  logic               out_of_range_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic               oor;
  } endpoints_t;

  // register mirror
  logic       inv_q;
  logic [6:0] max_deg_q;
  logic [9:0] lines_q;

  endpoints_t bar_q[$];

  longint rot_step[16] = '{29491200, 17409672, 9198793, 4669451, 2343787, 1173036,
                           586661, 293348, 146676, 73339, 36669, 18335, 9167, 4584,
                           2292, 1146};

  function automatic longint sat_q15(longint v);
    longint q;
    q = v / 32768;
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    return q;
  endfunction

  // rotate the unit vector to angle (tenths of a degree), Q1.15 out
  task automatic rotate(input longint ang, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit mirror;
    x = 652032874;
    y = 0;
    mirror = 0;
    if (ang > 1800) ang -= 3600;
    if (ang < -1800) ang += 3600;
    if (ang > 900) begin
      ang -= 1800;
      mirror = 1;
    end else if (ang < -900) begin
      ang += 1800;
      mirror = 1;
    end
    z = ang * 65536;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= rot_step[i];
      end else begin
        x += dx; y -= dy; z += rot_step[i];
      end
    end
    c = sat_q15(mirror ? -x : x);
    s = sat_q15(mirror ? -y : y);
  endtask

  task automatic predict_bar(input logic [5:0] col, input logic [4:0] row,
                             input logic signed [11:0] roll_w,
                             input logic signed [11:0] pitch_w,
                             output endpoints_t e);
    longint roll, pitch, lim, pclamp, sr, cr, sp, cp, sm, cm;
    longint span, ratio, xoff, yoff, xc, yc, bx, by;
    roll = roll_w;
    pitch = pitch_w;
    lim = (max_deg_q > 89) ? 890 : max_deg_q * 10;
    if (inv_q) begin
      roll = -roll; pitch = -pitch;
    end
    pclamp = pitch;
    if (pclamp > lim) pclamp = lim;
    if (pclamp < -lim) pclamp = -lim;
    rotate(roll, sr, cr);
    xoff = 0;
    yoff = 0;
    if (lim > 0) begin
      span = (longint'(lines_q) - 64) / 2;
      rotate(pclamp, sp, cp);
      rotate(lim, sm, cm);
      ratio = (sp * cm * 65536) / (cp * sm);
      xoff = (ratio * span * sr) / (64'sd1 <<< 31);
      yoff = (ratio * span * cr) / (64'sd1 <<< 31);
    end
    xc = longint'(col) * CHAR_WIDTH + CHAR_WIDTH / 2 - xoff;
    yc = (longint'(row) + (SYMBOL_ROWS - 1) / 2) * CHAR_HEIGHT + CHAR_HEIGHT / 2 - yoff;
    bx = longint'(BAR_CHARS * CHAR_WIDTH) * cr;
    by = longint'(BAR_CHARS * CHAR_WIDTH) * sr;
    e.sx  = 16'((xc * 32768 + bx) / 32768);
    e.sy  = 16'((yc * 32768 - by) / 32768);
    e.ex  = 16'((xc * 32768 - bx) / 32768);
    e.ey  = 16'((yc * 32768 + by) / 32768);
    e.oor = (pclamp != pitch);
  endtask

  task automatic flag_mismatch(input string what);
    $display("%0t ns  mismatch: %s", $time, what);
    fail_count++;
  endtask

  assign pending = bar_q.size();

  initial begin
    fail_count = 0;
    inv_q = 1'b0;
    max_deg_q = 7'd20;
    lines_q = 10'd480;
  end

  always @(posedge clk_i) begin
    endpoints_t e, got;
    if (rst_ni) begin
      // track register writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_INVERT) inv_q = cfg_wdata_i[0];
        else if (cfg_idx_i == CFG_MAX_PITCH) max_deg_q = cfg_wdata_i[6:0];
        else if (cfg_idx_i == CFG_SCREEN_LINES) lines_q = cfg_wdata_i;
      end
      // accepted word
      if (start && !busy) begin
        predict_bar(col_i, row_i, roll_i, pitch_i, e);
        bar_q.push_back(e);
      end
      // result word
      if (done_o) begin
        got = '{start_x_o, start_y_o, end_x_o, end_y_o, out_of_range_o};
        if (bar_q.size() == 0) flag_mismatch("result with nothing expected");
        else begin
          e = bar_q.pop_front();
          if (got.sx !== e.sx) flag_mismatch($sformatf("start_x %0d exp %0d", got.sx, e.sx));
          if (got.sy !== e.sy) flag_mismatch($sformatf("start_y %0d exp %0d", got.sy, e.sy));
          if (got.ex !== e.ex) flag_mismatch($sformatf("end_x %0d exp %0d", got.ex, e.ex));
          if (got.ey !== e.ey) flag_mismatch($sformatf("end_y %0d exp %0d", got.ey, e.ey));
          if (got.oor !== e.oor)
            flag_mismatch($sformatf("out_of_range %0b exp %0b", got.oor, e.oor));
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_horizon_line_endpoints_top.sv
`default_nettype none

module tb_horizon_line_endpoints_top;
  import hle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int SETTLE = 48;
  localparam int PHASES = 7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [5:0]         col_i = '0;
  logic [4:0]         row_i = '0;
  logic signed [11:0] roll_i = '0;
  logic signed [11:0] pitch_i = '0;
  logic               done_o;
  logic signed [15:0] start_x_o, start_y_o, end_x_o, end_y_o;
  logic               out_of_range_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_idx_i = '0;
  logic [9:0]         cfg_wdata_i = '0;
  int                 fail_count, pending;

  // register settings per phase: invert, pitch limit, screen lines
  int ph_inv[PHASES]   = '{0, 1, 0, 1, 0, 1, 0};
  int ph_lim[PHASES]   = '{20, 0, 89, 127, 1, 45, 30};
  int ph_lines[PHASES] = '{480, 64, 1023, 0, 63, 1023, 240};

  always #4 clk_i = ~clk_i;

  horizon_line_endpoints_top DUT (.*);

  horizon_line_endpoints_checker u_checker (.*);

  task automatic send_word(input logic [5:0] c, input logic [4:0] r,
                           input logic [11:0] ro, input logic [11:0] pi);
    start   <= 1'b1;
    col_i   <= c;
    row_i   <= r;
    roll_i  <= ro;
    pitch_i <= pi;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    repeat ($urandom_range(1, 14)) @(posedge clk_i);
  endtask

  // write all registers, then one stray index that must be ignored
  task automatic load_regs(input int inv, input int lim, input int lines);
    start <= 1'b0;
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_INVERT; cfg_wdata_i <= 10'(inv);
    @(posedge clk_i);
    cfg_idx_i <= CFG_MAX_PITCH; cfg_wdata_i <= 10'(lim);
    @(posedge clk_i);
    cfg_idx_i <= CFG_SCREEN_LINES; cfg_wdata_i <= 10'(lines);
    @(posedge clk_i);
    cfg_idx_i <= CFG_UNUSED; cfg_wdata_i <= 10'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // pitch often near the current limit so both sides of the clamp get hit
  function automatic logic [11:0] pick_pitch(input int lim);
    int l;
    l = (lim > 89) ? 890 : lim * 10;
    case ($urandom_range(0, 3))
      0: return 12'($urandom);
      1: return 12'(l + $signed($urandom_range(0, 8)) - 4);
      2: return 12'(-l + $signed($urandom_range(0, 8)) - 4);
      default: return 12'($signed($urandom_range(0, 2 * l)) - l);
    endcase
  endfunction

  initial begin
    int n_rand;
    int idle_ok;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      load_regs(ph_inv[p], ph_lim[p], ph_lines[p]);
      if (p == 0) begin
        // directed: field extremes, angle folds and wraps, clamp edges
        send_word(6'd0, 5'd0, 12'sd0, 12'sd0);
        send_word(6'd63, 5'd31, 12'sd0, 12'sd0);
        send_word(6'd63, 5'd0, -12'sd2048, 12'sd2047);
        send_word(6'd0, 5'd31, 12'sd2047, -12'sd2048);
        send_word(6'd10, 5'd5, 12'sd1800, 12'sd200);
        send_word(6'd10, 5'd5, -12'sd1800, -12'sd200);
        send_word(6'd20, 5'd8, 12'sd900, 12'sd201);
        send_word(6'd20, 5'd8, -12'sd900, -12'sd201);
        send_word(6'd20, 5'd8, 12'sd901, 12'sd199);
        send_word(6'd20, 5'd8, -12'sd901, -12'sd199);
        send_word(6'd30, 5'd15, 12'sd1801, 12'sd1800);
        send_word(6'd30, 5'd15, -12'sd1801, -12'sd1800);
        send_word(6'd42, 5'd21, 12'sd450, 12'sd100);
        send_word(6'd42, 5'd21, -12'sd450, -12'sd100);
        send_word(6'd1, 5'd1, 12'sd1, -12'sd1);
        send_word(6'h2a, 5'h15, 12'h555, 12'haaa);
        send_word(6'h15, 5'h0a, 12'haaa, 12'h555);
        drain();
      end
      n_rand = (p == PHASES - 1) ? 340 : 250;
      for (int i = 0; i < n_rand; i++) begin
        idle_ok = !(p == PHASES - 1 && i >= n_rand - 120);
        if (idle_ok && $urandom_range(0, 5) == 0) hold_off();
        send_word(6'($urandom), 5'($urandom),
                  ($urandom_range(0, 2) == 0) ? 12'($urandom)
                    : 12'($signed($urandom_range(0, 3600)) - 1800),
                  pick_pitch(ph_lim[p]));
      end
      drain();
    end

    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hdl
hdl/hle_pkg.sv
hdl/hle_cordic_cell.sv
hdl/hle_div_cell.sv
hdl/horizon_line_endpoints_top.sv
verif/horizon_line_endpoints_checker.sv
verif/tb_horizon_line_endpoints_top.sv
